[rtl/bmmd_pkg.sv]
// shared types, codes and constants for the banked memory map decoder
package bmmd_pkg;

	localparam logic [1:0] MAPPER_ROM_ONLY = 2'd0;
	localparam logic [1:0] MAPPER_MBC1     = 2'd1;
	localparam logic [1:0] MAPPER_MBC3     = 2'd2;

	localparam logic [3:0] REGION_ROM0   = 4'd0;
	localparam logic [3:0] REGION_ROMN   = 4'd1;
	localparam logic [3:0] REGION_VRAM   = 4'd2;
	localparam logic [3:0] REGION_EXTRAM = 4'd3;
	localparam logic [3:0] REGION_WRAM   = 4'd4;
	localparam logic [3:0] REGION_OAM    = 4'd5;
	localparam logic [3:0] REGION_IO     = 4'd6;
	localparam logic [3:0] REGION_HRAM   = 4'd7;
	localparam logic [3:0] REGION_NONE   = 4'd8;

	localparam logic       OP_READ  = 1'b0;
	localparam logic       OP_WRITE = 1'b1;

	localparam logic [15:0] ADDR_ROMN     = 16'h4000;
	localparam logic [15:0] ADDR_VRAM     = 16'h8000;
	localparam logic [15:0] ADDR_EXTRAM   = 16'hA000;
	localparam logic [15:0] ADDR_WRAM     = 16'hC000;
	localparam logic [15:0] ADDR_OAM      = 16'hFE00;
	localparam logic [15:0] ADDR_UNUSABLE = 16'hFEA0;
	localparam logic [15:0] ADDR_IO       = 16'hFF00;
	localparam logic [15:0] ADDR_HRAM     = 16'hFF80;
	localparam logic [15:0] ADDR_IE       = 16'hFFFF;

	localparam logic [15:0] ADDR_BANK_LO  = 16'h2000;
	localparam logic [15:0] ADDR_BANK_HI  = 16'h6000;

	localparam logic [3:0] RAM_ENABLE_KEY  = 4'hA;
	localparam logic [7:0] RAM_SEL_MAX     = 8'h03;
	localparam logic [7:0] FIXED_OPEN_BUS  = 8'hFF;
	localparam logic [7:0] FIXED_UNUSABLE  = 8'h00;

	localparam logic [6:0] ROM_SEL_RESET   = 7'd1;

	typedef struct packed {
		logic        opcode;
		logic [15:0] address;
		logic [7:0]  write_data;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  region;
		logic [13:0] region_offset;
		logic [6:0]  rom_bank_used;
		logic [1:0]  ram_bank_used;
		logic [20:0] rom_phys_address;
		logic        rom_phys_valid;
		logic        write_enable;
		logic        fixed_valid;
		logic [7:0]  fixed_value;
	} out_item_t;

	typedef struct packed {
		logic [6:0] rom_sel;
		logic [7:0] ram_sel;
		logic       ram_enable;
		logic       banking_mode;
	} bank_state_t;

endpackage

[rtl/banked_memory_map_decoder.sv]
// top level: input register, decode and result register of the memory map decoder
// a beat goes from the input register through the decode into the result register
// throughput: one beat per cycle while out_ready is high, set by the single decode stage between registers
// bank register writes take effect for the very next beat
// reset clears the stage valids, mapper kind, ram bank, enable and mode registers; rom bank resets to 1
module banked_memory_map_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  bmmd_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bmmd_pkg::out_item_t out_data
);

	logic                  valid_s1;
	bmmd_pkg::in_item_t    item_s1;
	logic                  valid_s2;
	bmmd_pkg::out_item_t   result_s2;
	logic                  advance;
	logic [1:0]            mapper_kind;
	bmmd_pkg::bank_state_t bank;
	bmmd_pkg::bank_state_t bank_next;
	bmmd_pkg::out_item_t   result;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	bmmd_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.upd_en      (advance),
		.bank_next   (bank_next),
		.mapper_kind (mapper_kind),
		.bank        (bank)
	);

	bmmd_decode u_decode (
		.item        (item_s1),
		.mapper_kind (mapper_kind),
		.bank        (bank),
		.result      (result),
		.bank_next   (bank_next)
	);

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

endmodule

[rtl/bmmd_regs.sv]
// mapper kind register and bank, enable and mode registers
module bmmd_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_wdata,
	input  logic                  upd_en,
	input  bmmd_pkg::bank_state_t bank_next,
	output logic [1:0]            mapper_kind,
	output bmmd_pkg::bank_state_t bank
);

	logic [1:0]            mapper_kind_q;
	bmmd_pkg::bank_state_t bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_kind_q <= bmmd_pkg::MAPPER_ROM_ONLY;
		end else if (cfg_we) begin
			mapper_kind_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q.rom_sel      <= bmmd_pkg::ROM_SEL_RESET;
			bank_q.ram_sel      <= '0;
			bank_q.ram_enable   <= 1'b0;
			bank_q.banking_mode <= 1'b0;
		end else if (upd_en) begin
			bank_q <= bank_next;
		end
	end

	assign mapper_kind = mapper_kind_q;
	assign bank        = bank_q;

endmodule

[rtl/bmmd_decode.sv]
// address decode and next bank register values for one bus access
module bmmd_decode (
	input  bmmd_pkg::in_item_t    item,
	input  logic [1:0]            mapper_kind,
	input  bmmd_pkg::bank_state_t bank,
	output bmmd_pkg::out_item_t   result,
	output bmmd_pkg::bank_state_t bank_next
);

	logic        is_mbc1;
	logic        is_mbc3;
	logic        is_write;
	logic [15:0] addr;
	logic [7:0]  data;
	logic [6:0]  romn_bank;
	logic        rtc_sel;
	logic        ram_reach;
	logic [4:0]  low5;
	logic [6:0]  low7;
	logic        key_ok;

	assign is_mbc1  = (mapper_kind == bmmd_pkg::MAPPER_MBC1);
	assign is_mbc3  = (mapper_kind == bmmd_pkg::MAPPER_MBC3);
	assign is_write = (item.opcode == bmmd_pkg::OP_WRITE);
	assign addr     = item.address;
	assign data     = item.write_data;
	assign rtc_sel  = is_mbc3 && (bank.ram_sel > bmmd_pkg::RAM_SEL_MAX);
	assign ram_reach = bank.ram_enable && !rtc_sel && (is_mbc1 || is_mbc3);
	assign low5     = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
	assign low7     = (data[6:0] == 7'd0) ? 7'd1 : data[6:0];
	assign key_ok   = (data[3:0] == bmmd_pkg::RAM_ENABLE_KEY);

	always_comb begin
		if (is_mbc1) begin
			romn_bank = bank.banking_mode ? {2'b00, bank.rom_sel[4:0]} : bank.rom_sel;
		end else if (is_mbc3) begin
			romn_bank = bank.rom_sel;
		end else begin
			romn_bank = 7'd1;
		end
	end

	// region decode
	always_comb begin
		result = '0;
		if (addr < bmmd_pkg::ADDR_ROMN) begin
			result.region           = bmmd_pkg::REGION_ROM0;
			result.region_offset    = addr[13:0];
			result.rom_phys_address = {7'd0, addr[13:0]};
			result.rom_phys_valid   = 1'b1;
		end else if (addr < bmmd_pkg::ADDR_VRAM) begin
			result.region           = bmmd_pkg::REGION_ROMN;
			result.region_offset    = addr[13:0];
			result.rom_bank_used    = romn_bank;
			result.rom_phys_address = {romn_bank, addr[13:0]};
			result.rom_phys_valid   = 1'b1;
		end else if (addr < bmmd_pkg::ADDR_EXTRAM) begin
			result.region        = bmmd_pkg::REGION_VRAM;
			result.region_offset = {1'b0, addr[12:0]};
			result.write_enable  = 1'b1;
		end else if (addr < bmmd_pkg::ADDR_WRAM) begin
			result.region        = bmmd_pkg::REGION_EXTRAM;
			result.region_offset = {1'b0, addr[12:0]};
			if (!rtc_sel && (is_mbc1 || is_mbc3)) begin
				result.ram_bank_used = bank.ram_sel[1:0];
			end
			if (ram_reach) begin
				result.write_enable = 1'b1;
			end else begin
				result.fixed_valid = 1'b1;
				result.fixed_value = bmmd_pkg::FIXED_OPEN_BUS;
			end
		end else if (addr < bmmd_pkg::ADDR_OAM) begin
			// echo area folds onto work ram
			result.region        = bmmd_pkg::REGION_WRAM;
			result.region_offset = {1'b0, addr[12:0]};
			result.write_enable  = 1'b1;
		end else if (addr < bmmd_pkg::ADDR_UNUSABLE) begin
			result.region        = bmmd_pkg::REGION_OAM;
			result.region_offset = {6'd0, addr[7:0]};
			result.write_enable  = 1'b1;
		end else if (addr < bmmd_pkg::ADDR_IO) begin
			result.region      = bmmd_pkg::REGION_NONE;
			result.fixed_valid = 1'b1;
			result.fixed_value = bmmd_pkg::FIXED_UNUSABLE;
		end else if (addr < bmmd_pkg::ADDR_HRAM) begin
			result.region        = bmmd_pkg::REGION_IO;
			result.region_offset = {6'd0, addr[7:0]};
			result.write_enable  = 1'b1;
		end else if (addr < bmmd_pkg::ADDR_IE) begin
			result.region        = bmmd_pkg::REGION_HRAM;
			result.region_offset = {7'd0, addr[6:0]};
			result.write_enable  = 1'b1;
		end else begin
			result.region        = bmmd_pkg::REGION_IO;
			result.region_offset = {6'd0, addr[7:0]};
			result.write_enable  = 1'b1;
		end
		if (is_write) begin
			result.fixed_valid = 1'b0;
			result.fixed_value = '0;
		end else begin
			result.write_enable = 1'b0;
		end
	end

	// mapper register writes
	always_comb begin
		bank_next = bank;
		if (is_write && (addr < bmmd_pkg::ADDR_VRAM)) begin
			if (is_mbc1) begin
				if (addr < bmmd_pkg::ADDR_BANK_LO) begin
					bank_next.ram_enable = key_ok;
				end else if (addr < bmmd_pkg::ADDR_ROMN) begin
					bank_next.rom_sel = {bank.rom_sel[6:5], low5};
				end else if (addr < bmmd_pkg::ADDR_BANK_HI) begin
					if (bank.banking_mode) begin
						bank_next.ram_sel = {6'd0, data[1:0]};
					end else begin
						bank_next.rom_sel = {data[1:0], bank.rom_sel[4:0]};
					end
				end else begin
					bank_next.banking_mode = data[0];
				end
			end else if (is_mbc3) begin
				if (addr < bmmd_pkg::ADDR_BANK_LO) begin
					bank_next.ram_enable = key_ok;
				end else if (addr < bmmd_pkg::ADDR_ROMN) begin
					bank_next.rom_sel = low7;
				end else if (addr < bmmd_pkg::ADDR_BANK_HI) begin
					bank_next.ram_sel = data;
				end
			end
		end
	end

endmodule
